// ===== rtl/wrlm_pkg.sv =====
// Shared constants and types for the windowed RMS level meter.
// Used by wrlm_divsqrt and windowed_rms_level_meter; depends on nothing.
`default_nettype none

package wrlm_pkg;

   localparam int SAMPLE_BITS_DEF = 10;
   localparam int COUNT_BITS_DEF  = 12;

   localparam int SUM_BITS      = 32;   // saturating sum of squares
   localparam int FRAC_BITS     = 16;   // sum is scaled by 2^16 before the divide
   localparam int MEAN_BITS     = SUM_BITS + FRAC_BITS;
   localparam int ROOT_BITS     = MEAN_BITS / 2;
   localparam int RMS_BITS      = 18;
   localparam int UNIT_BITS     = ROOT_BITS + 3;   // residual width of the shared subtractor
   localparam int STEP_BITS     = 6;
   localparam int DIV_STEPS     = MEAN_BITS;
   localparam int SQRT_STEPS    = ROOT_BITS;
   localparam int RSP_DATA_BITS = ((SUM_BITS + RMS_BITS + 7) / 8) * 8;

   localparam int DC_OFFSET_RESET_DEF = 512;
   localparam int WINDOW_RESET_DEF    = 2000;

   // Configuration register indexes.
   localparam logic CSR_DC_OFFSET     = 1'b0;
   localparam logic CSR_WINDOW_LENGTH = 1'b1;

   typedef struct packed {
      logic start;   // closing item: load sum and count, begin divide
      logic ack;     // result taken, return to idle
   } wrlm_ctl_type;

   typedef struct packed {
      logic busy;    // any phase other than idle
      logic done;    // result valid and held
   } wrlm_sts_type;

endpackage

`default_nettype wire

// ===== rtl/wrlm_divsqrt.sv =====
// Iterative mean and square-root unit: one shared subtractor does a restoring
// divide one quotient bit a cycle, then a square root one result bit a cycle. Uses wrlm_pkg.
`default_nettype none

module wrlm_divsqrt import wrlm_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire wrlm_ctl_type          ctl,
   input  wire logic [SUM_BITS-1:0]   sum,
   input  wire logic [COUNT_BITS:0]   count,
   output wrlm_sts_type               sts,
   output logic      [RMS_BITS-1:0]   rms
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_SQRT = 4'b0100,
      ST_HOLD = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [MEAN_BITS-1:0]  rad_ff, rad_in;
   logic [UNIT_BITS-1:0]  rem_ff, rem_in;
   logic [ROOT_BITS-1:0]  root_ff, root_in;
   logic [COUNT_BITS:0]   div_ff, div_in;

   logic [UNIT_BITS-1:0]  op_a, op_b, rest;
   logic [UNIT_BITS:0]    diff;
   logic                  ge;

   // Shared subtract-and-compare.
   always_comb begin
      if (state_ff == ST_DIV) begin
         op_a = {rem_ff[UNIT_BITS-2:0], rad_ff[MEAN_BITS-1]};
         op_b = UNIT_BITS'(div_ff);
      end else begin
         op_a = {rem_ff[UNIT_BITS-3:0], rad_ff[MEAN_BITS-1 -: 2]};
         op_b = UNIT_BITS'({root_ff, 2'b01});
      end
      diff = {1'b0, op_a} - {1'b0, op_b};
      ge   = ~diff[UNIT_BITS];
      rest = ge ? diff[UNIT_BITS-1:0] : op_a;
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      div_in   = div_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               state_in = ST_DIV;
               step_in  = '0;
               rad_in   = {sum, {FRAC_BITS{1'b0}}};
               rem_in   = '0;
               div_in   = count;
            end
         end
         ST_DIV: begin
            rem_in  = rest;
            rad_in  = {rad_ff[MEAN_BITS-2:0], ge};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(DIV_STEPS - 1)) begin
               // The quotient now sits in the radicand register.
               state_in = ST_SQRT;
               step_in  = '0;
               rem_in   = '0;
               root_in  = '0;
            end
         end
         ST_SQRT: begin
            rem_in  = rest;
            rad_in  = {rad_ff[MEAN_BITS-3:0], 2'b00};
            root_in = {root_ff[ROOT_BITS-2:0], ge};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(SQRT_STEPS - 1)) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (ctl.ack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      div_ff  <= div_in;
   end

   assign sts.busy = (state_ff != ST_IDLE);
   assign sts.done = (state_ff == ST_HOLD);
   assign rms = (root_ff[ROOT_BITS-1:RMS_BITS] != '0) ? {RMS_BITS{1'b1}}
                                                       : root_ff[RMS_BITS-1:0];

endmodule

`default_nettype wire

// ===== rtl/windowed_rms_level_meter.sv =====
// Windowed RMS level meter: top level. Uses wrlm_pkg and wrlm_divsqrt.
// Throughput: one sample item per cycle while a window fills; the item that closes a window
// holds off further items through its accept, 48 divide and 24 root steps of the shared
// subtractor and the load of the result register, longer while an earlier result still waits.
// The result is valid once those steps and that load are through. Synchronous active-high
// reset restores dc_offset 512, window_length 2000, and clears sum, count and valid flags.
`default_nettype none

module windowed_rms_level_meter import wrlm_pkg::*; #(
   parameter  int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter  int COUNT_BITS  = COUNT_BITS_DEF,
   localparam int REQ_BITS    = ((SAMPLE_BITS + 7) / 8) * 8,
   localparam int CSR_BITS    = (SAMPLE_BITS > COUNT_BITS) ? SAMPLE_BITS : COUNT_BITS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // Sample items.
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [REQ_BITS-1:0]       req_tdata,   // sample
   // Result items.
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic      [RSP_DATA_BITS-1:0]  rsp_tdata,   // squares_total, rms_q8
   // Configuration writes.
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic                      csr_index,
   input  wire logic [CSR_BITS-1:0]       csr_data
);

   localparam int SQ_BITS = 2 * SAMPLE_BITS;

   logic [SAMPLE_BITS-1:0]  dc_offset_ff, dc_offset_in;
   logic [COUNT_BITS-1:0]   window_ff, window_in;
   logic [SUM_BITS-1:0]     acc_ff, acc_in;
   logic [COUNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic [SUM_BITS-1:0]     total_ff, total_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SUM_BITS-1:0]     rsp_total_ff, rsp_total_in;
   logic [RMS_BITS-1:0]     rsp_rms_ff, rsp_rms_in;

   logic [SAMPLE_BITS-1:0]  sample, mag;
   logic [SQ_BITS-1:0]      square;
   logic [SUM_BITS:0]       sum_wide;
   logic [SUM_BITS-1:0]     sum_sat;
   logic [COUNT_BITS:0]     n_count, limit;
   logic                    accept, closing, load;

   wrlm_ctl_type            ctl;
   wrlm_sts_type            sts;
   logic [RMS_BITS-1:0]     unit_rms;

   // Accumulate path: remove offset, square, add with saturation.
   always_comb begin
      sample   = req_tdata[SAMPLE_BITS-1:0];
      mag      = (sample >= dc_offset_ff) ? (sample - dc_offset_ff) : (dc_offset_ff - sample);
      square   = mag * mag;
      sum_wide = {1'b0, acc_ff} + (SUM_BITS + 1)'(square);
      sum_sat  = sum_wide[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_wide[SUM_BITS-1:0];
      n_count  = {1'b0, cnt_ff} + 1'b1;
      // A zero window length stands for the full count range.
      limit    = (window_ff == '0) ? {1'b1, {COUNT_BITS{1'b0}}} : {1'b0, window_ff};
      // Closing on >= also covers a window shortened below the current count.
      closing  = (n_count >= limit);
   end

   assign req_tready = ~busy_ff;
   assign accept     = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;

   // The held result moves to the output register once that register is free.
   assign load      = sts.done & (~rsp_valid_ff | rsp_tready);
   assign ctl.start = accept & closing;
   assign ctl.ack   = load;

   wrlm_divsqrt #(
      .COUNT_BITS (COUNT_BITS)
   ) u_divsqrt (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .sum   (sum_sat),
      .count (n_count),
      .sts   (sts),
      .rms   (unit_rms)
   );

   always_comb begin
      dc_offset_in = dc_offset_ff;
      window_in    = window_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DC_OFFSET:     dc_offset_in = csr_data[SAMPLE_BITS-1:0];
            CSR_WINDOW_LENGTH: window_in    = csr_data[COUNT_BITS-1:0];
            default: begin
               dc_offset_in = dc_offset_ff;
            end
         endcase
      end

      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      total_in = total_ff;
      if (accept) begin
         if (closing) begin
            acc_in   = '0;
            cnt_in   = '0;
            busy_in  = 1'b1;
            total_in = sum_sat;
         end else begin
            acc_in = sum_sat;
            cnt_in = n_count[COUNT_BITS-1:0];
         end
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_total_in = rsp_total_ff;
      rsp_rms_in   = rsp_rms_ff;
      if (load) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_total_in = total_ff;
         rsp_rms_in   = unit_rms;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dc_offset_ff <= SAMPLE_BITS'(1 << (SAMPLE_BITS - 1));
         window_ff    <= COUNT_BITS'(WINDOW_RESET_DEF);
         acc_ff       <= '0;
         cnt_ff       <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dc_offset_ff <= dc_offset_in;
         window_ff    <= window_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      total_ff     <= total_in;
      rsp_total_ff <= rsp_total_in;
      rsp_rms_ff   <= rsp_rms_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_rms_ff, rsp_total_ff});

`ifndef SYNTHESIS
   // The root unit is never active unless a window close is pending.
   a_unit_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> !sts.busy)
      else $error("root unit active with no window close pending");

   // While a window close is pending the running sum and count stay cleared.
   a_cleared: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (acc_ff == '0) && (cnt_ff == '0))
      else $error("accumulator not cleared during window close");

   // A new result only appears after a pending window close.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(busy_ff))
      else $error("result item without a closed window");
`endif

endmodule

`default_nettype wire

// ===== dv/windowed_rms_level_meter_tb.sv =====
// Self-checking testbench for windowed_rms_level_meter: directed and random sample items,
// configuration phases and random stalls on both streams, with a scoreboard class.
// Depends on rtl/wrlm_pkg.sv and rtl/windowed_rms_level_meter.sv.
`default_nettype none

module windowed_rms_level_meter_tb import wrlm_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int  SAMPLE_W          = SAMPLE_BITS_DEF;
   localparam int  COUNT_W           = COUNT_BITS_DEF;
   localparam int  REQ_W             = ((SAMPLE_W + 7) / 8) * 8;
   localparam int  CSR_W             = (SAMPLE_W > COUNT_W) ? SAMPLE_W : COUNT_W;
   localparam int  SETTLE_CYCLES     = 100;       // well past the divide and root
   localparam int  ZERO_WINDOW_ITEMS = 400;
   localparam int  WIDE_WINDOW_ITEMS = 300;
   localparam int  RANDOM_ITEMS      = 700;
   localparam int  CYCLE_LIMIT       = 1000000;
   localparam int  REPORT_LIMIT      = 10;

   // One result item as the block should deliver it.
   typedef struct packed {
      logic [SUM_BITS-1:0] squares_total;
      logic [RMS_BITS-1:0] rms_q8;
   } level_type;

   // The scoreboard keeps its own copy of the registers, the running sum and the
   // sample count. Every accepted sample advances that copy; a sample that closes
   // a window queues the level the block must report for it.
   class rms_level_scoreboard;
      logic [SAMPLE_W-1:0] dc_offset;
      logic [COUNT_W-1:0]  window_length;
      logic [SUM_BITS-1:0] sum_of_squares;
      logic [COUNT_W-1:0]  samples_seen;
      level_type           expected_levels[$];
      int                  failures;
      int                  reports;

      function new();
         dc_offset      = SAMPLE_W'(DC_OFFSET_RESET_DEF);
         window_length  = COUNT_W'(WINDOW_RESET_DEF);
         sum_of_squares = '0;
         samples_seen   = '0;
         failures       = 0;
         reports        = 0;
      endfunction

      function void set_register(logic index, logic [CSR_W-1:0] value);
         // Only the low bits that the register holds take effect.
         if (index == CSR_DC_OFFSET) begin
            dc_offset = value[SAMPLE_W-1:0];
         end else if (index == CSR_WINDOW_LENGTH) begin
            window_length = value[COUNT_W-1:0];
         end
      endfunction

      // Largest r with r*r <= v, one result bit at a time from the top.
      function logic [31:0] floor_root(logic [63:0] v);
         logic [31:0] r;
         logic [31:0] trial;
         r = '0;
         for (int b = 31; b >= 0; b--) begin
            trial = r | (32'd1 << b);
            if (64'(trial) * 64'(trial) <= v) r = trial;
         end
         return r;
      endfunction

      function void note_sample(logic [SAMPLE_W-1:0] sample);
         logic [SAMPLE_W-1:0] magnitude;
         logic [SUM_BITS:0]   total;
         logic [COUNT_W:0]    count;
         logic [COUNT_W:0]    limit;
         logic [63:0]         mean;
         logic [31:0]         root;
         level_type           level;
         magnitude = (sample >= dc_offset) ? sample - dc_offset : dc_offset - sample;
         total = {1'b0, sum_of_squares} + (33'(magnitude) * 33'(magnitude));
         if (total[SUM_BITS]) total = {1'b0, {SUM_BITS{1'b1}}};
         count = {1'b0, samples_seen} + 1'b1;
         // A zero window length stands for the full counter range.
         limit = (window_length == '0) ? (COUNT_W+1)'(1 << COUNT_W) : {1'b0, window_length};
         if (count < limit) begin
            sum_of_squares = total[SUM_BITS-1:0];
            samples_seen   = count[COUNT_W-1:0];
            return;
         end
         // Closing sample; the count may exceed a window that was shortened.
         mean = {16'b0, total[SUM_BITS-1:0], 16'b0} / 64'(count);
         root = floor_root(mean);
         level.squares_total = total[SUM_BITS-1:0];
         level.rms_q8 = (root > 32'((1 << RMS_BITS) - 1)) ? {RMS_BITS{1'b1}} :
                        root[RMS_BITS-1:0];
         expected_levels.push_back(level);
         sum_of_squares = '0;
         samples_seen   = '0;
      endfunction

      function void check_level(logic [RSP_DATA_BITS-1:0] data);
         level_type wanted;
         level_type seen;
         seen.squares_total = data[SUM_BITS-1:0];
         seen.rms_q8        = data[SUM_BITS +: RMS_BITS];
         if (expected_levels.size() == 0) begin
            failures++;
            if (reports < REPORT_LIMIT) begin
               reports++;
               $display("ERROR: result item with none expected: sum %0d rms %0d",
                        seen.squares_total, seen.rms_q8);
            end
            return;
         end
         wanted = expected_levels.pop_front();
         if (seen.squares_total !== wanted.squares_total || seen.rms_q8 !== wanted.rms_q8) begin
            failures++;
            if (reports < REPORT_LIMIT) begin
               reports++;
               $display("ERROR: level mismatch: sum exp %0d got %0d, rms exp %0d got %0d",
                        wanted.squares_total, seen.squares_total, wanted.rms_q8, seen.rms_q8);
            end
         end
      endfunction

      function int pending_count();
         return expected_levels.size();
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_W-1:0]         req_tdata;    // sample
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;    // squares_total, rms_q8
   logic                     csr_valid;
   logic                     csr_ready;
   logic                     csr_index;
   logic [CSR_W-1:0]         csr_data;

   rms_level_scoreboard sb;
   bit                  steady;            // when set, neither stream idles
   int                  cycle_count = 0;
   logic [SAMPLE_W-1:0] cur_offset;        // mirror of dc_offset for picking samples

   windowed_rms_level_meter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // The result side stalls about a quarter of the cycles, except in the steady stretch.
   // It changes only at the falling edge, so the block sees it settled at the rising edge.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(0, 99) >= 25);
      end
   end

   // Results are taken at the rising edge; the values read here are those from before
   // the edge, since the block's own updates land later in the same step.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_level(rsp_tdata);
      end
   end

   // Offers one sample item, possibly after a few idle cycles, and notes it in the
   // scoreboard at the edge where it is taken. Entered and left at a falling edge.
   task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
      while (!steady && $urandom_range(0, 99) < 25) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {{(REQ_W-SAMPLE_W){1'b0}}, sample};
      do @(posedge clock); while (!req_tready);
      sb.note_sample(sample);
      @(negedge clock);
   endtask

   // Lets every pending level come out, then gives the block time to go idle.
   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (sb.pending_count() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One register write; only called while the block is idle.
   task automatic write_register(input logic index, input logic [CSR_W-1:0] value);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(index, value);
      if (index == CSR_DC_OFFSET) cur_offset = value[SAMPLE_W-1:0];
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Random sample: rail values, values close to the offset, or anything at all.
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int kind;
      int near;
      kind = $urandom_range(0, 99);
      if (kind < 15) return '0;
      if (kind < 30) return '1;
      if (kind < 60) begin
         near = int'(cur_offset) + $urandom_range(0, 16) - 8;
         if (near < 0) near = 0;
         if (near > (1 << SAMPLE_W) - 1) near = (1 << SAMPLE_W) - 1;
         return SAMPLE_W'(near);
      end
      return SAMPLE_W'($urandom());
   endfunction

   initial begin
      int sent;
      int span;
      logic [CSR_W-1:0] value;

      sb          = new();
      steady      = 1'b0;
      cur_offset  = SAMPLE_W'(DC_OFFSET_RESET_DEF);
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_valid   = 1'b0;
      csr_index   = CSR_DC_OFFSET;
      csr_data    = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. A one-sample window at the reset offset turns every item into a
      // level, which puts the rails, mid-scale and alternating bit patterns through.
      write_register(CSR_WINDOW_LENGTH, CSR_W'(1));
      send_sample(10'd0);
      send_sample(10'd1023);
      send_sample(10'd512);
      send_sample(10'd511);
      send_sample(10'd513);
      send_sample(10'h2AA);
      send_sample(10'h155);
      wait_idle();

      // Offset at both ends; the second write carries bits above the register width,
      // which the block has to drop.
      write_register(CSR_DC_OFFSET, CSR_W'(0));
      send_sample(10'd1023);
      send_sample(10'd0);
      wait_idle();
      write_register(CSR_DC_OFFSET, '1);
      send_sample(10'd0);
      send_sample(10'd1023);
      wait_idle();

      // A window shortened while partly filled closes on the very next sample and
      // divides by the number of samples it really holds.
      write_register(CSR_DC_OFFSET, CSR_W'(300));
      write_register(CSR_WINDOW_LENGTH, CSR_W'(8));
      repeat (5) send_sample(pick_sample());
      wait_idle();
      write_register(CSR_WINDOW_LENGTH, CSR_W'(3));
      send_sample(pick_sample());
      wait_idle();
      write_register(CSR_WINDOW_LENGTH, CSR_W'(2));
      repeat (2) send_sample(pick_sample());
      wait_idle();

      // Window length zero means the full counter range, so a long run of full-scale
      // samples must not close it. Shortening it then closes it on the next sample
      // with a large sum over many samples.
      write_register(CSR_DC_OFFSET, CSR_W'(0));
      write_register(CSR_WINDOW_LENGTH, CSR_W'(0));
      repeat (ZERO_WINDOW_ITEMS) send_sample(10'd1023);
      wait_idle();
      write_register(CSR_WINDOW_LENGTH, CSR_W'(1));
      send_sample(10'd1023);
      wait_idle();

      // The largest nonzero window, with the magnitude coming from the other side. The
      // random part that follows shortens this partly filled window.
      write_register(CSR_DC_OFFSET, CSR_W'(1023));
      write_register(CSR_WINDOW_LENGTH, '1);
      for (int i = 0; i < WIDE_WINDOW_ITEMS; i++) begin
         send_sample((i % 97 == 0) ? pick_sample() : 10'd0);
      end
      wait_idle();

      // Random phases: new settings, then a run of samples. Phases usually stop in the
      // middle of a window, so the next setting often shortens or stretches a partly
      // filled one. Short windows keep levels frequent.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_idle();
         if ($urandom_range(0, 1) == 1 || sent == 0) begin
            case ($urandom_range(0, 9))
               0: value = CSR_W'(0);
               1: value = CSR_W'(1023);
               default: value = CSR_W'($urandom());
            endcase
            write_register(CSR_DC_OFFSET, value);
         end
         case ($urandom_range(0, 9))
            0: value = CSR_W'(1);
            1: value = CSR_W'($urandom_range(33, 200));
            default: value = CSR_W'($urandom_range(1, 32));
         endcase
         write_register(CSR_WINDOW_LENGTH, value);
         span = $urandom_range(1, 120);
         for (int i = 0; i < span; i++) begin
            // A stretch in the middle of the random part runs without any idling.
            steady = (sent >= 250 && sent < 450);
            send_sample(pick_sample());
            sent++;
         end
         steady = 1'b0;
      end

      wait_idle();
      if (sb.failures == 0 && sb.pending_count() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== windowed_rms_level_meter.f =====
rtl/wrlm_pkg.sv
rtl/wrlm_divsqrt.sv
rtl/windowed_rms_level_meter.sv
dv/windowed_rms_level_meter_tb.sv
